[sv/nopt_pkg.sv]
// ----------------------------------------------------------------------------
// nopt_pkg: shared types and constants of the note pairing table
// Field widths, stream packing layouts and the layout of one table entry.
// ----------------------------------------------------------------------------
package nopt_pkg;

  // Table depth and stored position width.
  localparam int PITCH_COUNT = 128;
  localparam int POS_WIDTH   = 32;
  localparam int PITCH_IDX_W = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;

  // Field widths of the stream items.
  localparam int EV_POS_W    = 32;
  localparam int EV_PITCH_W  = 7;
  localparam int EV_VOLUME_W = 8;
  localparam int EV_FLAGS_W  = 8;
  localparam int EV_STRING_W = 4;
  localparam int EV_CLEF_W   = 8;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 104;

  // Input transaction; the last field declared sits in the lowest bits.
  typedef struct packed {
    logic [4:0]                    pad;
    logic signed [EV_CLEF_W-1:0]   clef_pos;
    logic [EV_STRING_W-1:0]        string_no;
    logic [EV_FLAGS_W-1:0]         flags;
    logic [EV_VOLUME_W-1:0]        volume;
    logic [EV_PITCH_W-1:0]         pitch;
    logic [EV_POS_W-1:0]           pos;
  } event_t;

  // Output transaction; the last field declared sits in the lowest bits.
  typedef struct packed {
    logic [4:0]                    pad;
    logic signed [EV_CLEF_W-1:0]   clef_pos;
    logic [EV_STRING_W-1:0]        string_no;
    logic [EV_FLAGS_W-1:0]         flags;
    logic [EV_VOLUME_W-1:0]        volume;
    logic [EV_PITCH_W-1:0]         pitch;
    logic [EV_POS_W-1:0]           note_end;
    logic [EV_POS_W-1:0]           note_start;
  } note_t;

  // One open note-on as kept in the table memory.
  typedef struct packed {
    logic signed [EV_CLEF_W-1:0]   clef_pos;
    logic [EV_STRING_W-1:0]        string_no;
    logic [EV_FLAGS_W-1:0]         flags;
    logic [EV_VOLUME_W-1:0]        volume;
    logic [POS_WIDTH-1:0]          pos;
  } entry_t;

endpackage

[sv/note_on_off_pairing_table_top.sv]
// ----------------------------------------------------------------------------
// note_on_off_pairing_table_top: pairs note-off events with open note-ons
// One pitch-indexed table of open notes, read, modified and written per event.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the s_axis channel, one transaction per event. A note-on
//   (nonzero volume) opens its pitch if the pitch is free; a repeated note-on
//   is dropped. A note-off (zero volume) on an open pitch sends one completed
//   note on the m_axis channel and frees the pitch; otherwise it sends nothing.
//   An event passes the decision stage, then the output register. One event can
//   be taken every cycle while the receiver does not stall: the table entry is
//   read from a synchronous memory while the previous event is decided, and a
//   write to the same pitch in that cycle is forwarded around the memory.
//   Reset clears every valid bit at once, so no note is open afterwards and
//   the block takes events in the first cycle after reset. Notes that are
//   never closed stay in the table until reset.
//   When the receiver stalls, the finished note waits in the output register
//   and one more event waits in the decision stage; input ready then drops.
// ----------------------------------------------------------------------------
module note_on_off_pairing_table_top (
  input  logic                             clk,
  input  logic                             rst,
  // pos, pitch, volume, flags, string_no, clef_pos (lowest bit up), zero fill
  input  logic [nopt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // note_start, note_end, pitch, volume, flags, string_no, clef_pos, zero fill
  output logic [nopt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready
);

  localparam int PitchCount = nopt_pkg::PITCH_COUNT;
  localparam int PosW       = nopt_pkg::POS_WIDTH;
  localparam int IdxW       = nopt_pkg::PITCH_IDX_W;
  localparam int PosOutW    = nopt_pkg::EV_POS_W;

  // Table storage: valid bits in flops, entries in a synchronous memory.
  logic [PitchCount-1:0]  open_valid;
  nopt_pkg::entry_t       open_entry [PitchCount];
  nopt_pkg::entry_t       rd_data;

  // Decision stage registers.
  logic                   s1_valid;
  nopt_pkg::event_t       s1_ev;
  logic [IdxW-1:0]        s1_idx;
  logic                   s1_in_range;
  logic                   fwd_hit;
  nopt_pkg::entry_t       fwd_data;

  // Output register.
  logic                   out_valid;
  nopt_pkg::note_t        out_note;

  nopt_pkg::event_t       in_ev;
  logic [IdxW-1:0]        in_idx;
  logic                   in_range;
  logic                   accept;
  logic                   s1_adv;
  nopt_pkg::entry_t       entry_cur;
  nopt_pkg::entry_t       wr_data;
  logic                   is_on;
  logic                   is_open;
  logic                   wr_en;
  logic                   emit;
  nopt_pkg::note_t        note_next;

  // Input decode and handshake.
  assign in_ev    = nopt_pkg::event_t'(s_axis_tdata);
  assign in_idx   = IdxW'(in_ev.pitch);
  assign in_range = 32'(in_ev.pitch) < 32'(PitchCount);
  assign s1_adv   = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || s1_adv;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // Decision for the event in the stage: open, close or drop.
  always_comb begin
    entry_cur = fwd_hit ? fwd_data : rd_data;
    is_on     = s1_ev.volume != '0;
    is_open   = open_valid[s1_idx];
    wr_en     = s1_valid && s1_adv && s1_in_range && is_on && !is_open;
    emit      = s1_valid && s1_in_range && !is_on && is_open;

    wr_data.pos       = PosW'(s1_ev.pos);
    wr_data.volume    = s1_ev.volume;
    wr_data.flags     = s1_ev.flags;
    wr_data.string_no = s1_ev.string_no;
    wr_data.clef_pos  = s1_ev.clef_pos;

    note_next            = '0;
    note_next.note_start = PosOutW'(entry_cur.pos);
    note_next.note_end   = PosOutW'(PosW'(s1_ev.pos));
    note_next.pitch      = s1_ev.pitch;
    note_next.volume     = entry_cur.volume;
    note_next.flags      = entry_cur.flags;
    note_next.string_no  = entry_cur.string_no;
    note_next.clef_pos   = entry_cur.clef_pos;
  end

  // Entry memory: read on accept, write when a note-on opens its pitch.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= open_entry[in_idx];
    end
    if (wr_en) begin
      open_entry[s1_idx] <= wr_data;
    end
  end

  // Valid bits follow the decision of each event leaving the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_valid <= '0;
    end else if (s1_valid && s1_adv && s1_in_range) begin
      if (wr_en) begin
        open_valid[s1_idx] <= 1'b1;
      end else if (emit) begin
        open_valid[s1_idx] <= 1'b0;
      end
    end
  end

  // Stage control, with forwarding of a same-pitch write made this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ev       <= in_ev;
      s1_idx      <= in_idx;
      s1_in_range <= in_range;
      fwd_hit     <= wr_en && (s1_idx == in_idx);
      fwd_data    <= wr_data;
    end
  end

  // Output register holds a finished note until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_note <= note_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_note;

endmodule

[sv/nopt_checker.sv]
// ----------------------------------------------------------------------------
// nopt_checker: port-level checks for the note pairing table
// Watches both stream channels of the top level over time.
// ----------------------------------------------------------------------------
module nopt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic [nopt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [nopt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready
);

  logic in_xfer;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // No result is pending in the cycle after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result pending after reset");

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // With the output empty, the block always takes an event.
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

  // A result cannot appear unless an input transaction is still in flight.
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && !in_xfer && !$past(in_xfer) |=> !m_axis_tvalid)
    else $error("result appeared without an input transaction");

endmodule

bind note_on_off_pairing_table_top nopt_checker u_nopt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

[bench/note_on_off_pairing_table_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// note_on_off_pairing_table_top_test: self-checking bench of the pairing table
// Drives note events into the table and predicts each completed note from a
// private copy of the open-note table. Every note that leaves the block is
// compared field by field with the oldest prediction. Both stream sides idle
// at random, and one stretch of the run has no idling at all.
// ----------------------------------------------------------------------------
module note_on_off_pairing_table_top_test;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 6;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic [nopt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [nopt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;

  // Predicted open-note table and the notes still to come out.
  bit                 note_open [nopt_pkg::PITCH_COUNT];
  nopt_pkg::entry_t   note_held [nopt_pkg::PITCH_COUNT];
  nopt_pkg::note_t    pending_notes[$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  bit                 gaps_on = 1'b1;

  note_on_off_pairing_table_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #5 clk = ~clk;

  // Pair one event against the table; returns 1 when it completes a note.
  function automatic bit pair_event(input nopt_pkg::event_t ev,
                                    output nopt_pkg::note_t done);
    int unsigned p;
    p = ev.pitch;
    done = '0;
    if (p >= nopt_pkg::PITCH_COUNT) return 1'b0;
    if (ev.volume != '0) begin
      // A note-on only opens a free pitch; a repeated one is dropped.
      if (!note_open[p]) begin
        note_held[p].pos       = ev.pos[nopt_pkg::POS_WIDTH-1:0];
        note_held[p].volume    = ev.volume;
        note_held[p].flags     = ev.flags;
        note_held[p].string_no = ev.string_no;
        note_held[p].clef_pos  = ev.clef_pos;
        note_open[p] = 1'b1;
      end
      return 1'b0;
    end
    // A note-off on an idle pitch gives nothing.
    if (!note_open[p]) return 1'b0;
    done.note_start = 32'(note_held[p].pos);
    done.note_end   = 32'(ev.pos[nopt_pkg::POS_WIDTH-1:0]);
    done.pitch      = ev.pitch;
    done.volume     = note_held[p].volume;
    done.flags      = note_held[p].flags;
    done.string_no  = note_held[p].string_no;
    done.clef_pos   = note_held[p].clef_pos;
    note_open[p] = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_note(input nopt_pkg::note_t got, input nopt_pkg::note_t want);
    if (got.note_start !== want.note_start)
      report_mismatch($sformatf("note start is %0h, expected %0h",
                                got.note_start, want.note_start));
    if (got.note_end !== want.note_end)
      report_mismatch($sformatf("note end is %0h, expected %0h",
                                got.note_end, want.note_end));
    if (got.pitch !== want.pitch)
      report_mismatch($sformatf("note pitch is %0h, expected %0h", got.pitch, want.pitch));
    if (got.volume !== want.volume)
      report_mismatch($sformatf("note volume is %0h, expected %0h",
                                got.volume, want.volume));
    if (got.flags !== want.flags)
      report_mismatch($sformatf("note flags is %0h, expected %0h", got.flags, want.flags));
    if (got.string_no !== want.string_no)
      report_mismatch($sformatf("note string is %0h, expected %0h",
                                got.string_no, want.string_no));
    if (got.clef_pos !== want.clef_pos)
      report_mismatch($sformatf("note clef is %0h, expected %0h",
                                got.clef_pos, want.clef_pos));
    if (got.pad !== '0)
      report_mismatch($sformatf("note fill is %0h, expected 0", got.pad));
  endtask

  // Predict on every accepted event and check every accepted note.
  always @(posedge clk) begin : note_monitor
    nopt_pkg::note_t done;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (pair_event(nopt_pkg::event_t'(s_axis_tdata), done))
          pending_notes.push_back(done);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_notes.size() == 0) begin
          report_mismatch($sformatf("note %0h arrived with none expected", m_axis_tdata));
        end else begin
          check_note(nopt_pkg::note_t'(m_axis_tdata), pending_notes.pop_front());
        end
      end
    end
  end

  // The receiver stalls at random while idling is enabled.
  always @(posedge clk) begin
    m_axis_tready <= !(gaps_on && $urandom_range(99) < 21);
  end

  // Cycle counter that ends a run which hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic nopt_pkg::event_t make_event(input logic [31:0] pos,
                                                  input logic [6:0] pitch,
                                                  input logic [7:0] volume,
                                                  input logic [7:0] flags,
                                                  input logic [3:0] string_no,
                                                  input logic signed [7:0] clef_pos);
    nopt_pkg::event_t ev;
    ev = '0;
    ev.pos       = pos;
    ev.pitch     = pitch;
    ev.volume    = volume;
    ev.flags     = flags;
    ev.string_no = string_no;
    ev.clef_pos  = clef_pos;
    return ev;
  endfunction

  // Event with random attributes for a given pitch and volume.
  function automatic nopt_pkg::event_t random_event(input logic [6:0] pitch,
                                                    input logic [7:0] volume);
    return make_event($urandom, pitch, volume, 8'($urandom), 4'($urandom), 8'($urandom));
  endfunction

  // Send one event; returns at the edge that accepted it.
  task automatic send_event(input nopt_pkg::event_t ev);
    while (gaps_on && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= ev;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Hold off the sender until every predicted note has come out.
  task automatic drain_notes;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Field extremes, repeated note-on, stray note-off, end before start.
  task automatic test_directed;
    send_event(make_event(32'h0, 7'd0, 8'hff, 8'hff, 4'hf, 8'sd127));
    send_event(make_event(32'hffff_ffff, 7'd127, 8'h01, 8'h00, 4'h0, 8'sh80));
    send_event(make_event(32'h1234_5678, 7'd0, 8'h50, 8'h11, 4'h3, 8'sd5));
    send_event(make_event(32'h5, 7'd0, 8'h00, 8'h00, 4'h0, 8'sd0));
    send_event(make_event(32'h6, 7'd0, 8'h00, 8'hff, 4'hf, -8'sd1));
    send_event(make_event(32'h7, 7'd5, 8'h00, 8'h00, 4'h0, 8'sd0));
    send_event(make_event(32'h0, 7'd127, 8'h00, 8'haa, 4'h9, 8'sd3));
    send_event(make_event(32'h8000_0000, 7'd64, 8'h80, 8'ha5, 4'h5, -8'sd1));
    send_event(make_event(32'h7fff_ffff, 7'd64, 8'h00, 8'h5a, 4'ha, 8'sd100));
    send_event(make_event(32'haaaa_aaaa, 7'd85, 8'h55, 8'h5a, 4'h8, 8'sd0));
    send_event(make_event(32'h5555_5555, 7'd85, 8'h00, 8'h00, 4'h0, 8'sd0));
    send_event(make_event(32'h0000_ffff, 7'd42, 8'haa, 8'h0f, 4'h7, -8'sd86));
    send_event(make_event(32'hffff_0000, 7'd42, 8'h00, 8'h00, 4'h0, 8'sd0));
    send_event(make_event(32'h1, 7'd127, 8'h00, 8'h00, 4'h0, 8'sd0));
    drain_notes();
  endtask

  // Back-to-back events on one pitch with no idling, so table forwarding is hit.
  task automatic test_same_pitch_streak;
    logic [6:0] pitch;
    gaps_on = 1'b0;
    for (int i = 0; i < 40; i++) begin
      pitch = 7'($urandom_range(127));
      send_event(random_event(pitch, 8'($urandom_range(1, 255))));
      if ($urandom_range(3) == 0)
        send_event(random_event(pitch, 8'($urandom_range(1, 255))));
      send_event(random_event(pitch, 8'h00));
      if ($urandom_range(3) == 0) send_event(random_event(pitch, 8'h00));
    end
    drain_notes();
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed note pairs over a small pitch pool, some noise mixed in.
  task automatic test_random_pairs(input int count);
    logic [6:0] pool [8];
    logic [6:0] pitch;
    logic [7:0] volume;
    foreach (pool[i]) pool[i] = 7'($urandom_range(127));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80) pitch = pool[$urandom_range(7)];
      else pitch = 7'($urandom_range(127));
      if (note_open[pitch])
        volume = ($urandom_range(99) < 75) ? 8'h00 : 8'($urandom_range(1, 255));
      else
        volume = ($urandom_range(99) < 85) ? 8'($urandom_range(1, 255)) : 8'h00;
      send_event(random_event(pitch, volume));
      if (i % 200 == 199) drain_notes();
    end
    drain_notes();
  endtask

  // Fully random events over every pitch and volume.
  task automatic test_random_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_event(random_event(7'($urandom_range(127)),
                              ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom)));
    end
    drain_notes();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_same_pitch_streak();
    test_random_pairs(600);
    test_random_noise(150);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
